@@ hdl/cbh_pkg.sv @@
// ----------------------------------------------------------------------------
// cbh_pkg
// Constants, tables and helper functions shared by the block hash files.
// ----------------------------------------------------------------------------
`default_nettype none

package cbh_pkg;

    typedef logic [31:0] word_t;

    // Operands of one compression round step
    typedef struct packed {
        word_t      a;
        word_t      b;
        word_t      c;
        word_t      d;
        word_t      w;
        word_t      k;
        logic [4:0] rot;
        logic       pass2;
    } cbh_rnd_in_t;

    localparam word_t IV [8] = '{
        32'h71b2b78a, 32'hec9ef898, 32'h3145caee, 32'hed119de9,
        32'hd83a713b, 32'h4996668b, 32'h4434d6b9, 32'ha8dca679
    };

    localparam word_t KT [64] = '{
        32'hc4343361, 32'he8929933, 32'hf468ebb7, 32'h32da638a,
        32'h86ee3abc, 32'h5accfd6e, 32'h836c6cab, 32'hf25f1553,
        32'h662b56b2, 32'h1143aabb, 32'hd87638d2, 32'h2f773b58,
        32'hff5a6aa7, 32'hee4e3eea, 32'h32faeaa3, 32'h19fb9b84,
        32'ha9bdb6e7, 32'hcc6525a8, 32'h4c2f6b14, 32'hb28b6fb1,
        32'h1237de8e, 32'hf5e8e273, 32'h78d51bd2, 32'h8ae39eb5,
        32'h5c6da38a, 32'hb4a4deb3, 32'h225b811b, 32'h50e62412,
        32'h818740a5, 32'h8b7eff2b, 32'hb78f6a2f, 32'h82cf8997,
        32'hd5f91f82, 32'h0723be5c, 32'h616f9748, 32'h43f64717,
        32'h8b76ea5e, 32'h35948bae, 32'h0023e714, 32'h54573c13,
        32'h3784d133, 32'h051cd836, 32'h5227c588, 32'hed73b5d8,
        32'he2571b48, 32'h0231fb8f, 32'hc68c895b, 32'hfc61e74f,
        32'h4334e2c9, 32'h36887d97, 32'h199ea71d, 32'h0245e5d9,
        32'h346c8894, 32'h765e9ce3, 32'h12f99f33, 32'h139e2e57,
        32'hae61fc8d, 32'hc1e8d8a4, 32'hff51afd7, 32'hed558ccd,
        32'hc4ceb9fe, 32'h1a85ec53, 32'hcc9e2d51, 32'h1b873593
    };

    // Message word order of both round passes
    localparam logic [3:0] RW [32] = '{
        4'd0, 4'd7, 4'd14, 4'd5, 4'd12, 4'd3, 4'd10, 4'd1,
        4'd8, 4'd15, 4'd6, 4'd13, 4'd4, 4'd11, 4'd2, 4'd9,
        4'd1, 4'd6, 4'd11, 4'd0, 4'd5, 4'd10, 4'd15, 4'd4,
        4'd9, 4'd14, 4'd3, 4'd8, 4'd13, 4'd2, 4'd7, 4'd12
    };

    // Round rotations, indexed by {pass, step mod 4}
    localparam logic [4:0] RND_ROT [8] = '{
        5'd6, 5'd10, 5'd15, 5'd21, 5'd5, 5'd9, 5'd14, 5'd20
    };

    // Message word and rotation of each mixing step
    localparam logic [3:0] MIX_W [32] = '{
        4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12, 4'd14,
        4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd13, 4'd15,
        4'd4, 4'd8, 4'd7, 4'd5, 4'd1, 4'd3, 4'd2, 4'd13,
        4'd6, 4'd9, 4'd11, 4'd14, 4'd12, 4'd15, 4'd0, 4'd10
    };

    localparam logic [4:0] MIX_ROT [32] = '{
        5'd15, 5'd16, 5'd17, 5'd18, 5'd15, 5'd16, 5'd17, 5'd18,
        5'd11, 5'd13, 5'd17, 5'd19, 5'd11, 5'd13, 5'd17, 5'd19,
        5'd10, 5'd15, 5'd20, 5'd25, 5'd10, 5'd15, 5'd20, 5'd25,
        5'd11, 5'd13, 5'd17, 5'd19, 5'd11, 5'd13, 5'd17, 5'd19
    };

    // Finishing rotation per target word A..H
    localparam logic [4:0] FIN_ROT [8] = '{
        5'd19, 5'd17, 5'd15, 5'd13, 5'd19, 5'd17, 5'd15, 5'd13
    };

    localparam logic [4:0] MIX_COPY_STEP = 5'd23;
    localparam logic [3:0] W_COPY_DST    = 4'd14;
    localparam logic [3:0] W_COPY_SRC    = 4'd13;

    localparam word_t      FMIX_C1    = 32'h85ebca6b;
    localparam word_t      FMIX_C2    = 32'hc2b2ae35;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'h3f;

    function automatic word_t rotl(input word_t x, input logic [4:0] r);
        logic [63:0] t;
        t = {x, x} << r;
        return t[63:32];
    endfunction

    function automatic word_t mul32(input word_t a, input word_t b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

    // (rotl(x, r) + add) * 5 + k, with the times five as shift and add
    function automatic word_t fin(input word_t x, input logic [4:0] r,
                                  input word_t add, input word_t k);
        word_t s;
        s = rotl(x, r) + add;
        return (s << 2) + s + k;
    endfunction

endpackage

`default_nettype wire

@@ hdl/custom_256bit_block_hash.sv @@
// ----------------------------------------------------------------------------
// custom_256bit_block_hash
// 256-bit chaining hash over a byte stream, with block buffer and chaining
// words held in synchronous memories.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, data_word,           | into block
//          | byte_count, last                         |
//  out     | out_valid, out_stall, digest_word,       | out of block
//          | word_index, last_word                    |
//
//  Bytes enter the buffer memory one per cycle unless a full block is being
//  compressed; a new item waits until the last one's bytes are in. A full block
//  costs a load of the eight chaining words, 32 round steps, 32 mixing steps
//  (M1, M2, M3) and a fold of each chaining word. A last item adds padding
//  bytes, a final compression and ORD, OLD, OWAIT per digest word. Reset
//  restores the initial chaining constants through per-entry valid bits. A
//  stalled output holds its item; no input is taken until the digest is out.
// ----------------------------------------------------------------------------
`default_nettype none

module custom_256bit_block_hash
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [31:0] data_word,
    input  wire  [2:0]  byte_count,
    input  wire         last,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_PUT   = 13'b0000000000010,
        ST_LD    = 13'b0000000000100,
        ST_RND   = 13'b0000000001000,
        ST_M1    = 13'b0000000010000,
        ST_M2    = 13'b0000000100000,
        ST_M3    = 13'b0000001000000,
        ST_F0    = 13'b0000010000000,
        ST_F1    = 13'b0000100000000,
        ST_F2    = 13'b0001000000000,
        ST_ORD   = 13'b0010000000000,
        ST_OLD   = 13'b0100000000000,
        ST_OWAIT = 13'b1000000000000
    } state_t;

    typedef enum logic [2:0] {
        PAD_MARK = 3'b001,
        PAD_ZERO = 3'b010,
        PAD_LEN  = 3'b100
    } pad_t;

    state_t      state_reg, state_next;
    pad_t        pad_reg, pad_next;
    logic [4:0]  step_reg, step_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic        done_reg, done_next;
    logic [7:0]  chain_vld_reg, chain_vld_next;
    logic        out_vld_reg, out_vld_next;

    logic [31:0] data_reg, data_next;
    logic [2:0]  nbytes_reg, nbytes_next;
    logic        last_reg, last_next;
    logic [2:0]  bi_reg, bi_next;
    logic [2:0]  li_reg, li_next;
    logic [31:0] cur_reg, cur_next;
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] p1_reg, p1_next;
    logic [31:0] p2_reg, p2_next;
    logic [31:0] old_reg, old_next;
    logic [31:0] out_word_reg, out_word_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_last_reg, out_last_next;

    logic [31:0] buf_mem [16];
    logic [31:0] buf_rdata_reg;
    logic        buf_we;
    logic [3:0]  buf_waddr, buf_raddr;
    logic [31:0] buf_wdata;

    logic [31:0] chain_mem [8];
    logic [31:0] chain_rdata_reg;
    logic        chain_rvld_reg;
    logic [2:0]  chain_raddr_reg;
    logic        chain_we;
    logic [2:0]  chain_raddr;
    logic [31:0] chain_wdata;
    logic [31:0] chain_val;

    logic        put_en, put_data;
    logic [7:0]  put_byte;
    logic [31:0] cur_word;

    cbh_pkg::cbh_rnd_in_t rnd_op;
    logic [31:0] rnd_q;

    logic [2:0]  tsel, tnext, tsrc, sm1;
    logic        special;
    logic [31:0] mix_k, mix_rot, mix_prod, fin_src, fold_x, fold_h;

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_vld_reg;
    assign digest_word = out_word_reg;
    assign word_index  = out_idx_reg;
    assign last_word   = out_last_reg;

    // Unwritten chain entries read as their initial constant
    assign chain_val = chain_rvld_reg ? chain_rdata_reg : cbh_pkg::IV[chain_raddr_reg];

    assign tsel    = step_reg[2:0];
    assign tnext   = step_reg[2:0] + 3'd1;
    assign tsrc    = step_reg[2:0] - 3'd4;
    assign sm1     = step_reg[2:0] - 3'd1;
    assign special = (step_reg == cbh_pkg::MIX_COPY_STEP);
    assign mix_k   = cbh_pkg::KT[{1'b1, step_reg}];

    cbh_round u_round
    (
        .op (rnd_op),
        .q  (rnd_q)
    );

    always_comb
    begin
        rnd_op.pass2 = step_reg[4];
        rnd_op.w     = buf_rdata_reg;
        rnd_op.k     = cbh_pkg::KT[{1'b0, step_reg}];
        rnd_op.rot   = cbh_pkg::RND_ROT[{step_reg[4], step_reg[1:0]}];
        if (step_reg[4])
        begin
            rnd_op.a = v_reg[4];
            rnd_op.b = v_reg[5];
            rnd_op.c = v_reg[6];
            rnd_op.d = v_reg[7];
        end
        else
        begin
            rnd_op.a = v_reg[0];
            rnd_op.b = v_reg[1];
            rnd_op.c = v_reg[2];
            rnd_op.d = v_reg[3];
        end
    end

    // Byte to append this cycle: data bytes first, then padding on a last item
    always_comb
    begin
        put_en   = 1'b0;
        put_data = 1'b0;
        put_byte = 8'd0;
        if (state_reg == ST_PUT)
        begin
            if (bi_reg < nbytes_reg)
            begin
                put_en   = 1'b1;
                put_data = 1'b1;
                put_byte = data_reg[{bi_reg[1:0], 3'b000} +: 8];
            end
            else if (last_reg)
            begin
                put_en = 1'b1;
                case (pad_reg)
                    PAD_MARK: put_byte = cbh_pkg::PAD_BYTE;
                    PAD_ZERO: put_byte = (fill_reg == cbh_pkg::LEN_POS) ? bitlen_reg[7:0] : 8'd0;
                    PAD_LEN:  put_byte = bitlen_reg[{li_reg, 3'b000} +: 8];
                    default:  put_byte = 8'd0;
                endcase
            end
        end
        cur_word = (fill_reg[1:0] == 2'd0) ? 32'd0 : cur_reg;
        cur_word[{fill_reg[1:0], 3'b000} +: 8] = put_byte;
    end

    always_comb
    begin
        state_next     = state_reg;
        pad_next       = pad_reg;
        step_next      = step_reg;
        fill_next      = fill_reg;
        bitlen_next    = bitlen_reg;
        done_next      = done_reg;
        chain_vld_next = chain_vld_reg;
        out_vld_next   = out_vld_reg;
        data_next      = data_reg;
        nbytes_next    = nbytes_reg;
        last_next      = last_reg;
        bi_next        = bi_reg;
        li_next        = li_reg;
        cur_next       = cur_reg;
        v_next         = v_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        old_next       = old_reg;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        buf_we         = 1'b0;
        buf_waddr      = 4'd0;
        buf_wdata      = 32'd0;
        buf_raddr      = 4'd0;
        chain_we       = 1'b0;
        chain_raddr    = 3'd0;
        chain_wdata    = 32'd0;
        mix_rot        = cbh_pkg::rotl(p1_reg, cbh_pkg::MIX_ROT[step_reg]);
        mix_prod       = 32'd0;
        fin_src        = 32'd0;
        fold_x         = v_reg[tsel];
        fold_h         = p2_reg ^ (p2_reg >> 16);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    data_next   = data_word;
                    nbytes_next = (byte_count > 3'd4) ? 3'd4 : byte_count;
                    last_next   = last;
                    bi_next     = 3'd0;
                    li_next     = 3'd0;
                    pad_next    = PAD_MARK;
                    done_next   = 1'b0;
                    state_next  = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (put_data)
                begin
                    bi_next     = bi_reg + 3'd1;
                    bitlen_next = bitlen_reg + 64'd8;
                end
                else if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    case (pad_reg)
                        PAD_MARK: pad_next = PAD_ZERO;
                        PAD_ZERO:
                        begin
                            if (fill_reg == cbh_pkg::LEN_POS)
                            begin
                                pad_next = PAD_LEN;
                                li_next  = 3'd1;
                            end
                        end
                        PAD_LEN:
                        begin
                            li_next = li_reg + 3'd1;
                            if (li_reg == 3'd7)
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default: pad_next = PAD_MARK;
                    endcase
                end
                if (put_en)
                begin
                    fill_next = fill_reg + 6'd1;
                    cur_next  = cur_word;
                    buf_we    = 1'b1;
                    buf_waddr = fill_reg[5:2];
                    buf_wdata = cur_word;
                    if (fill_reg == cbh_pkg::BLOCK_LAST)
                    begin
                        state_next = ST_LD;
                        step_next  = 5'd0;
                    end
                end
            end
            ST_LD:
            begin
                chain_raddr = step_reg[2:0];
                if (step_reg != 5'd0)
                begin
                    v_next[sm1] = chain_val;
                end
                if (step_reg == 5'd8)
                begin
                    buf_raddr  = cbh_pkg::RW[0];
                    step_next  = 5'd0;
                    state_next = ST_RND;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_RND:
            begin
                // Rotate the four working words of the active pass
                if (step_reg[4])
                begin
                    v_next[4] = v_reg[7];
                    v_next[5] = rnd_q;
                    v_next[6] = v_reg[5];
                    v_next[7] = v_reg[6];
                end
                else
                begin
                    v_next[0] = v_reg[3];
                    v_next[1] = rnd_q;
                    v_next[2] = v_reg[1];
                    v_next[3] = v_reg[2];
                end
                if (step_reg == 5'd31)
                begin
                    buf_raddr  = cbh_pkg::MIX_W[0];
                    step_next  = 5'd0;
                    state_next = ST_M1;
                end
                else
                begin
                    buf_raddr = cbh_pkg::RW[step_reg + 5'd1];
                    step_next = step_reg + 5'd1;
                end
            end
            ST_M1:
            begin
                p1_next    = cbh_pkg::mul32(buf_rdata_reg, v_reg[tsel]);
                state_next = ST_M2;
            end
            ST_M2:
            begin
                // The copy step stores the rotated product into word 14
                mix_prod   = cbh_pkg::mul32(special ? p1_reg : mix_rot, mix_k);
                buf_we     = 1'b1;
                buf_waddr  = special ? cbh_pkg::W_COPY_DST : cbh_pkg::MIX_W[step_reg];
                buf_wdata  = special ? mix_rot : mix_prod;
                p2_next    = mix_prod;
                state_next = ST_M3;
            end
            ST_M3:
            begin
                if (special)
                begin
                    buf_we    = 1'b1;
                    buf_waddr = cbh_pkg::W_COPY_SRC;
                    buf_wdata = p2_reg;
                end
                // G and H are rebuilt from C and D
                fin_src = (tsel[2:1] == 2'b11) ? v_reg[tsrc] : (v_reg[tsel] ^ p2_reg);
                v_next[tsel] = cbh_pkg::fin(fin_src, cbh_pkg::FIN_ROT[tsel], v_reg[tnext],
                                            mix_k);
                buf_raddr = cbh_pkg::MIX_W[step_reg + 5'd1];
                if (step_reg == 5'd31)
                begin
                    step_next  = 5'd0;
                    state_next = ST_F0;
                end
                else
                begin
                    step_next  = step_reg + 5'd1;
                    state_next = ST_M1;
                end
            end
            ST_F0:
            begin
                chain_raddr = tsel;
                p1_next     = cbh_pkg::mul32(fold_x ^ (fold_x >> 16), cbh_pkg::FMIX_C1);
                state_next  = ST_F1;
            end
            ST_F1:
            begin
                p2_next    = cbh_pkg::mul32(p1_reg ^ (p1_reg >> 13), cbh_pkg::FMIX_C2);
                old_next   = chain_val;
                state_next = ST_F2;
            end
            ST_F2:
            begin
                chain_we             = 1'b1;
                chain_wdata          = old_reg + (fold_x ^ fold_h);
                chain_vld_next[tsel] = 1'b1;
                if (step_reg == 5'd7)
                begin
                    step_next  = 5'd0;
                    state_next = done_reg ? ST_ORD : ST_PUT;
                end
                else
                begin
                    step_next  = step_reg + 5'd1;
                    state_next = ST_F0;
                end
            end
            ST_ORD:
            begin
                chain_raddr = tsel;
                state_next  = ST_OLD;
            end
            ST_OLD:
            begin
                out_word_next = chain_val;
                out_idx_next  = tsel;
                out_last_next = (tsel == 3'd7);
                out_vld_next  = 1'b1;
                state_next    = ST_OWAIT;
            end
            ST_OWAIT:
            begin
                if (!out_stall)
                begin
                    out_vld_next = 1'b0;
                    if (tsel == 3'd7)
                    begin
                        // Return to the reset state
                        chain_vld_next = 8'd0;
                        bitlen_next    = 64'd0;
                        fill_next      = 6'd0;
                        done_next      = 1'b0;
                        step_next      = 5'd0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        step_next  = step_reg + 5'd1;
                        state_next = ST_ORD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pad_reg       <= PAD_MARK;
            step_reg      <= 5'd0;
            fill_reg      <= 6'd0;
            bitlen_reg    <= 64'd0;
            done_reg      <= 1'b0;
            chain_vld_reg <= 8'd0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pad_reg       <= pad_next;
            step_reg      <= step_next;
            fill_reg      <= fill_next;
            bitlen_reg    <= bitlen_next;
            done_reg      <= done_next;
            chain_vld_reg <= chain_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        nbytes_reg   <= nbytes_next;
        last_reg     <= last_next;
        bi_reg       <= bi_next;
        li_reg       <= li_next;
        cur_reg      <= cur_next;
        v_reg        <= v_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        old_reg      <= old_next;
        out_word_reg <= out_word_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_waddr] <= buf_wdata;
        end
        buf_rdata_reg <= buf_mem[buf_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (chain_we)
        begin
            chain_mem[tsel] <= chain_wdata;
        end
        chain_rdata_reg <= chain_mem[chain_raddr];
        chain_rvld_reg  <= chain_vld_reg[chain_raddr];
        chain_raddr_reg <= chain_raddr;
    end

`ifndef SYNTH
    a_out_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (state_reg == ST_OWAIT))
        else $error("output item valid outside the output wait state");

    a_full_block_compresses: assert property (@(posedge clk) disable iff (!rst_n)
        (put_en && (fill_reg == cbh_pkg::BLOCK_LAST)) |=> (state_reg == ST_LD))
        else $error("full block did not start compression");

    a_mix_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_M3) && (step_reg == 5'd31)) |=> (state_reg == ST_F0))
        else $error("mixing did not hand over to the fold");

    a_done_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg != ST_IDLE))
        else $error("digest pending while idle");
`endif

endmodule

`default_nettype wire

@@ hdl/cbh_round.sv @@
// ----------------------------------------------------------------------------
// cbh_round
// One step of the two round passes: F2 on the first pass, F1 on the second.
// ----------------------------------------------------------------------------
`default_nettype none

module cbh_round
(
    input  wire cbh_pkg::cbh_rnd_in_t op,
    output logic [31:0]               q
);

    logic [31:0] f;
    logic [31:0] sum;

    always_comb
    begin
        if (op.pass2)
        begin
            f = op.b ^ (op.c & (op.d ^ op.b));
        end
        else
        begin
            f = op.b ^ (op.d | ~op.c);
        end
        sum = op.a + f + op.w + op.k;
        q   = cbh_pkg::rotl(sum, op.rot) + op.b;
    end

endmodule

`default_nettype wire
